// File: rtl/ilist_pkg.sv
// Package: operation codes, status codes and cell control type for the indexed list engine.
package ilist_pkg;

   // Operation codes carried by an input item
   localparam logic [2:0] OP_ADD_FRONT = 3'd0;
   localparam logic [2:0] OP_ADD_REAR  = 3'd1;
   localparam logic [2:0] OP_REM_FRONT = 3'd2;
   localparam logic [2:0] OP_REM_REAR  = 3'd3;
   localparam logic [2:0] OP_REM_AT    = 3'd4;
   localparam logic [2:0] OP_INS_AT    = 3'd5;

   // Status codes returned with each result item
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // Port widths fixed by the item format
   localparam int OP_W    = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic open_slot;   // shift toward the rear from the slot, load new element at the slot
      logic close_slot;  // shift toward the front from the slot
   } cell_ctrl_type;

endpackage

// File: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: decode, length tracking, cell chain and result register.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | op, position, value
//   rsp_    | out       | rsp_valid/rsp_stall  | removed_value, status, count, empty_res
//
// One item per cycle: every cell shifts in parallel, so an operation completes in the cycle
// it is accepted and its result appears in the output register on the next cycle.
// Throughput is set by the single result register: req_stall rises only while a result waits
// and rsp_stall is high. Reset clears the length and result valid; cell contents need no reset.
module indexed_list_engine #(
   parameter int DEPTH      = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ilist_pkg::OP_W-1:0]      req_op,
   input  logic [ilist_pkg::POS_W-1:0]     req_position,
   input  logic [ilist_pkg::VALUE_W-1:0]   req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ilist_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [ilist_pkg::STAT_W-1:0]    rsp_status,
   output logic [ilist_pkg::COUNT_W-1:0]   rsp_count,
   output logic                            rsp_empty_res
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((LEN_W > ilist_pkg::POS_W) ? LEN_W : ilist_pkg::POS_W) + 1;
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

   logic [LEN_W-1:0]                 length_ff, length_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ilist_pkg::VALUE_W-1:0]    removed_ff, removed_in;
   logic [ilist_pkg::STAT_W-1:0]     status_ff, status_in;
   logic [ilist_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                             empty_ff, empty_in;

   logic                             accept;
   logic                             do_open, do_close;
   logic [IDX_W-1:0]                 slot_idx;
   logic [ilist_pkg::STAT_W-1:0]     status_calc;
   logic [CMP_W-1:0]                 pos_c, len_c;
   logic                             is_full, is_empty;
   ilist_pkg::cell_ctrl_type         ctrl;
   logic [ELEM_WIDTH-1:0]            new_elem;
   logic [ELEM_WIDTH-1:0]            cell_data [DEPTH];
   logic [ELEM_WIDTH-1:0]            cell_tap  [DEPTH];
   logic [ELEM_WIDTH-1:0]            read_bus;

   // Accept whenever the result register is free or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_c    = CMP_W'(req_position);
   assign len_c    = CMP_W'(length_ff);
   assign is_full  = (length_ff == FULL_LEN);
   assign is_empty = (length_ff == '0);
   assign new_elem = ELEM_WIDTH'(req_value);

   // Decode the operation into a slot, a shift direction and a status
   always_comb begin
      do_open     = 1'b0;
      do_close    = 1'b0;
      slot_idx    = '0;
      status_calc = ilist_pkg::ST_OK;
      unique case (req_op)
         ilist_pkg::OP_ADD_FRONT: begin
            if (is_full) status_calc = ilist_pkg::ST_FULL;
            else         do_open     = 1'b1;
         end
         ilist_pkg::OP_ADD_REAR: begin
            slot_idx = IDX_W'(length_ff);
            if (is_full) status_calc = ilist_pkg::ST_FULL;
            else         do_open     = 1'b1;
         end
         ilist_pkg::OP_REM_FRONT: begin
            if (is_empty) status_calc = ilist_pkg::ST_UNDER;
            else          do_close    = 1'b1;
         end
         ilist_pkg::OP_REM_REAR: begin
            slot_idx = IDX_W'(length_ff - LEN_W'(1));
            if (is_empty) status_calc = ilist_pkg::ST_UNDER;
            else          do_close    = 1'b1;
         end
         ilist_pkg::OP_REM_AT: begin
            slot_idx = IDX_W'(pos_c - CMP_W'(1));
            if (pos_c == '0 || pos_c > len_c) status_calc = ilist_pkg::ST_RANGE;
            else                               do_close    = 1'b1;
         end
         ilist_pkg::OP_INS_AT: begin
            slot_idx = IDX_W'(pos_c - CMP_W'(1));
            if (pos_c == '0 || pos_c > len_c + CMP_W'(1)) status_calc = ilist_pkg::ST_RANGE;
            else if (is_full)                               status_calc = ilist_pkg::ST_FULL;
            else                                            do_open     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign ctrl.open_slot  = accept && do_open;
   assign ctrl.close_slot = accept && do_close;

   // Build the chain of cells, each linked to its front and rear neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_WIDTH-1:0] front_nb, rear_nb;
      if (g == 0) begin : g_first
         assign front_nb = cell_data[g];
      end else begin : g_mid_front
         assign front_nb = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign rear_nb = cell_data[g];
      end else begin : g_mid_rear
         assign rear_nb = cell_data[g+1];
      end
      ilist_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot_idx   (slot_idx),
         .new_data   (new_elem),
         .front_data (front_nb),
         .rear_data  (rear_nb),
         .data       (cell_data[g]),
         .tap        (cell_tap[g])
      );
   end

   // Collect the element at the slot from the one-hot taps
   always_comb begin
      read_bus = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_bus = read_bus | cell_tap[i];
      end
   end

   // Advance the length on a successful add or remove
   always_comb begin
      length_in = length_ff;
      if (ctrl.open_slot)       length_in = length_ff + LEN_W'(1);
      else if (ctrl.close_slot) length_in = length_ff - LEN_W'(1);
   end

   // Load the result register on accept, drop its valid when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      removed_in   = removed_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = do_close ? ilist_pkg::VALUE_W'(read_bus) : '0;
         status_in    = status_calc;
         count_in     = ilist_pkg::COUNT_W'(length_in);
         empty_in     = (length_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff <= removed_in;
      status_ff  <= status_in;
      count_ff   <= count_in;
      empty_ff   <= empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_count         = count_ff;
   assign rsp_empty_res     = empty_ff;

   // Length never passes the depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= FULL_LEN)
      else $error("list length above depth");

   // A successful add grows the list by exactly one
   a_open_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.open_slot |=> length_ff == $past(length_ff) + LEN_W'(1))
      else $error("add did not grow the list by one");

   // A failed operation leaves the length alone
   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && status_calc != ilist_pkg::ST_OK) |=> length_ff == $past(length_ff))
      else $error("failed operation changed the length");

   // A stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

// File: rtl/ilist_cell.sv
// One storage cell of the list chain: holds one element and shifts with its neighbors.
module ilist_cell #(
   parameter int ELEM_WIDTH = 32,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  ilist_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]        slot_idx,
   input  logic [ELEM_WIDTH-1:0]   new_data,
   input  logic [ELEM_WIDTH-1:0]   front_data,
   input  logic [ELEM_WIDTH-1:0]   rear_data,
   output logic [ELEM_WIDTH-1:0]   data,
   output logic [ELEM_WIDTH-1:0]   tap
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;

   // Pick the next element by comparing this cell's place with the slot
   always_comb begin
      data_in = data_ff;
      if (ctrl.open_slot) begin
         if (MY_IDX == slot_idx) begin
            data_in = new_data;
         end else if (MY_IDX > slot_idx) begin
            data_in = front_data;
         end
      end else if (ctrl.close_slot) begin
         if (MY_IDX >= slot_idx) begin
            data_in = rear_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Drive the element onto the read bus only when this cell is the slot
   assign tap  = (MY_IDX == slot_idx) ? data_ff : '0;
   assign data = data_ff;

endmodule
